FILE: sv/epoch_seconds_to_civil_date_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for epoch_seconds_to_civil_date
// Concurrent checks clocked on clk, switched off while rst_n is low.
// -----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CIVIL_DATE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CIVIL_DATE_ASSERT_SVH

// same-cycle implication
`define ESCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ESCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/escd_pkg.sv
// -----------------------------------------------------------------------------
// escd_pkg
// Shared types and constants of the seconds-to-date pipeline.
// -----------------------------------------------------------------------------
`default_nettype none

package escd_pkg;

    // register stages from input to output register
    localparam int NUM_STAGES = 10;

    typedef logic [NUM_STAGES-1:0] escd_stage_en_t;

    // result of the day split, stage 3
    typedef struct packed {
        logic [16:0] tod;   // seconds into the day
        logic [17:0] doe;   // day of the 400-year era
        logic        era5;  // era starting 2000-03-01 (else 1600-03-01)
        logic [2:0]  wday;  // 0 = Sunday
    } escd_split_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } escd_time_t;

    typedef struct packed {
        logic [2:0] weekday;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [7:0] years_since_1900;
    } escd_date_t;

endpackage

`default_nettype wire

FILE: sv/escd_day_split.sv
// -----------------------------------------------------------------------------
// escd_day_split
// Stages 1 to 3: floor split of the timestamp into day number and time of
// day, then day of era, era and weekday.
// -----------------------------------------------------------------------------
`default_nettype none

module escd_day_split
    import escd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [31:0] seconds_since_1970,
    input  wire escd_stage_en_t     stage_en,
    output escd_split_t             split
);

    // 24856 days: lifts any 32-bit time above zero
    localparam logic [32:0] DAY_BIAS    = 33'd2147558400;
    // 86400 = 128 * 675; low 7 bits bypass the divide
    localparam int          RECIP_SHIFT = 36;
    localparam logic [26:0] RECIP_675   =
        27'(((64'd1 << RECIP_SHIFT) + 64'd674) / 64'd675);
    localparam logic [25:0] DAY_UNITS   = 26'd675;
    // 719468 - 24856 - 4 * 146097: biased day to day of era
    localparam logic [17:0] DOE_SHIFT   = 18'd110224;
    localparam logic [17:0] DAYS_ERA    = 18'd146097;
    // (719468 - 24856 + 3) mod 7
    localparam logic [16:0] WDAY_OFFSET = 17'd5;

    function automatic logic [2:0] mod7(input logic [16:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
           + 6'(x[14:12]) + 6'(x[16:15]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        if (s2 >= 4'd7)
        begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

    logic [32:0]  biased_reg, biased_next;
    logic [52:0]  day_prod;
    logic [15:0]  dayq_reg, dayq_next;
    logic [25:0]  units_reg;
    logic [6:0]   frac_reg;
    logic [25:0]  units_rem;
    logic [17:0]  doe_sum;
    escd_split_t  split_reg, split_next;

    always_comb
    begin
        biased_next = {seconds_since_1970[31], seconds_since_1970} + DAY_BIAS;
        day_prod    = 53'(biased_reg[32:7]) * 53'(RECIP_675);
        dayq_next   = day_prod[51:36];

        units_rem   = units_reg - 26'(dayq_reg) * DAY_UNITS;
        doe_sum     = 18'(dayq_reg) + DOE_SHIFT;
        split_next.tod  = {units_rem[9:0], frac_reg};
        split_next.era5 = (doe_sum >= DAYS_ERA);
        split_next.doe  = split_next.era5 ? (doe_sum - DAYS_ERA) : doe_sum;
        split_next.wday = mod7(17'(dayq_reg) + WDAY_OFFSET);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            biased_reg <= biased_next;
        end
        if (stage_en[1])
        begin
            dayq_reg  <= dayq_next;
            units_reg <= biased_reg[32:7];
            frac_reg  <= biased_reg[6:0];
        end
        if (stage_en[2])
        begin
            split_reg <= split_next;
        end
    end

    assign split = split_reg;

endmodule

`default_nettype wire

FILE: sv/escd_time_of_day.sv
// -----------------------------------------------------------------------------
// escd_time_of_day
// Stages 4 to 10: hour, minute and second from the seconds into the day.
// -----------------------------------------------------------------------------
`default_nettype none

module escd_time_of_day
    import escd_pkg::*;
(
    input  wire logic           clk,
    input  wire logic [16:0]    tod,
    input  wire escd_stage_en_t stage_en,
    output escd_time_t          time_out
);

    localparam logic [17:0] RECIP_3600 = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
    localparam logic [12:0] RECIP_60   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
    localparam logic [16:0] SECS_HOUR  = 17'd3600;
    localparam logic [11:0] SECS_MIN   = 12'd60;
    // stages 7 to 10: delay line up to the output register
    localparam int          DLY        = 4;

    logic [34:0] hour_prod;
    logic [24:0] min_prod;
    logic [16:0] hour_rem;
    logic [11:0] sec_rem;

    logic [16:0] tod4_reg;
    logic [4:0]  hour4_reg, hour4_next, hour5_reg, hour6_reg;
    logic [11:0] rem5_reg, rem5_next, rem6_reg;
    logic [5:0]  min6_reg, min6_next;
    escd_time_t  time7_next;
    escd_time_t  dly_reg [DLY];

    always_comb
    begin
        hour_prod  = 35'(tod) * 35'(RECIP_3600);
        hour4_next = hour_prod[33:29];
        hour_rem   = tod4_reg - 17'(hour4_reg) * SECS_HOUR;
        rem5_next  = hour_rem[11:0];
        min_prod   = 25'(rem5_reg) * 25'(RECIP_60);
        min6_next  = min_prod[23:18];
        sec_rem    = rem6_reg - 12'(min6_reg) * SECS_MIN;
        time7_next.hour   = hour6_reg;
        time7_next.minute = min6_reg;
        time7_next.second = sec_rem[5:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            tod4_reg  <= tod;
            hour4_reg <= hour4_next;
        end
        if (stage_en[4])
        begin
            rem5_reg  <= rem5_next;
            hour5_reg <= hour4_reg;
        end
        if (stage_en[5])
        begin
            rem6_reg  <= rem5_reg;
            min6_reg  <= min6_next;
            hour6_reg <= hour5_reg;
        end
        if (stage_en[6])
        begin
            dly_reg[0] <= time7_next;
        end
        for (int i = 1; i < DLY; i++)
        begin
            if (stage_en[6 + i])
            begin
                dly_reg[i] <= dly_reg[i - 1];
            end
        end
    end

    assign time_out = dly_reg[DLY - 1];

endmodule

`default_nettype wire

FILE: sv/escd_civil_date.sv
// -----------------------------------------------------------------------------
// escd_civil_date
// Stages 4 to 10: year of era, day of year, month and day from day of era.
// -----------------------------------------------------------------------------
`default_nettype none

module escd_civil_date
    import escd_pkg::*;
(
    input  wire logic           clk,
    input  wire escd_split_t    split,
    input  wire escd_stage_en_t stage_en,
    output escd_date_t          date
);

    localparam logic [18:0] RECIP_1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] RECIP_365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  RECIP_100  = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] RECIP_153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
    localparam logic [17:0] DAYS_CENT1 = 18'd36524;
    localparam logic [17:0] DAYS_CENT2 = 18'd73048;
    localparam logic [17:0] DAYS_CENT3 = 18'd109572;
    localparam logic [17:0] DAYS_LAST  = 18'd146096;
    localparam logic [17:0] DAYS_YEAR  = 18'd365;
    localparam logic [3:0]  MP_JAN     = 4'd10;   // March-based index of January
    localparam logic [9:0]  YEAR_ERA5  = 10'd100;  // 2000 - 1900
    localparam logic [9:0]  YEAR_ERA4  = 10'(-300); // 1600 - 1900

    // first day of each March-based month within the year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        unique case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    logic [36:0] q1460_prod, yoe_prod;
    logic [18:0] y100_prod;
    logic [22:0] mp_prod;
    logic [10:0] mp_arg;
    logic [17:0] doy_full;
    logic [8:0]  mday_full;

    // carried along the stages that use them
    logic [17:0] doe4_reg, doe5_reg, doe6_reg, doe7_reg;
    logic [2:0]  wday_reg [4:9];
    logic        era_reg  [4:9];

    logic [6:0]  q1460_reg, q1460_next;
    logic [2:0]  cent_reg, cent_next;
    logic        last_reg, last_next;
    logic [17:0] t5_reg, t5_next;
    logic [8:0]  yoe6_reg, yoe6_next, yoe7_reg, yoe8_reg, yoe9_reg;
    logic [1:0]  y100_reg, y100_next;
    logic [17:0] y365_reg, y365_next;
    logic [8:0]  doy8_reg, doy8_next, doy9_reg;
    logic [3:0]  mp9_reg, mp9_next;
    escd_date_t  date_reg, date_next;

    always_comb
    begin
        q1460_prod = 37'(split.doe) * 37'(RECIP_1460);
        q1460_next = q1460_prod[35:29];
        cent_next  = 3'(split.doe >= DAYS_CENT1) + 3'(split.doe >= DAYS_CENT2)
                   + 3'(split.doe >= DAYS_CENT3) + 3'(split.doe >= DAYS_LAST);
        last_next  = (split.doe == DAYS_LAST);

        t5_next    = doe4_reg - 18'(q1460_reg) + 18'(cent_reg) - 18'(last_reg);

        yoe_prod   = 37'(t5_reg) * 37'(RECIP_365);
        yoe6_next  = yoe_prod[35:27];

        y100_prod  = 19'(yoe6_reg) * 19'(RECIP_100);
        y100_next  = y100_prod[17:16];
        y365_next  = 18'(yoe6_reg) * DAYS_YEAR;

        doy_full   = doe7_reg - (y365_reg + 18'(yoe7_reg[8:2]) - 18'(y100_reg));
        doy8_next  = doy_full[8:0];

        mp_arg     = {doy8_reg, 2'b00} + 11'(doy8_reg) + 11'd2;
        mp_prod    = 23'(mp_arg) * 23'(RECIP_153);
        mp9_next   = mp_prod[22:19];

        mday_full  = doy9_reg - month_start(mp9_reg) + 9'd1;
        date_next.weekday      = wday_reg[9];
        date_next.day_of_month = mday_full[4:0];
        date_next.month_index  = (mp9_reg < MP_JAN) ? (mp9_reg + 4'd2) : (mp9_reg - MP_JAN);
        date_next.years_since_1900 = 8'(10'(yoe9_reg)
                                   + (era_reg[9] ? YEAR_ERA5 : YEAR_ERA4)
                                   + 10'(mp9_reg >= MP_JAN));
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            doe4_reg    <= split.doe;
            era_reg[4]  <= split.era5;
            wday_reg[4] <= split.wday;
            q1460_reg   <= q1460_next;
            cent_reg    <= cent_next;
            last_reg    <= last_next;
        end
        for (int s = 5; s <= 9; s++)
        begin
            if (stage_en[s - 1])
            begin
                era_reg[s]  <= era_reg[s - 1];
                wday_reg[s] <= wday_reg[s - 1];
            end
        end
        if (stage_en[4])
        begin
            doe5_reg <= doe4_reg;
            t5_reg   <= t5_next;
        end
        if (stage_en[5])
        begin
            doe6_reg <= doe5_reg;
            yoe6_reg <= yoe6_next;
        end
        if (stage_en[6])
        begin
            doe7_reg <= doe6_reg;
            yoe7_reg <= yoe6_reg;
            y100_reg <= y100_next;
            y365_reg <= y365_next;
        end
        if (stage_en[7])
        begin
            yoe8_reg <= yoe7_reg;
            doy8_reg <= doy8_next;
        end
        if (stage_en[8])
        begin
            yoe9_reg <= yoe8_reg;
            doy9_reg <= doy8_reg;
            mp9_reg  <= mp9_next;
        end
        if (stage_en[9])
        begin
            date_reg <= date_next;
        end
    end

    assign date = date_reg;

endmodule

`default_nettype wire

FILE: sv/epoch_seconds_to_civil_date.sv
// -----------------------------------------------------------------------------
// epoch_seconds_to_civil_date
// Signed seconds since 1970-01-01 to time of day, weekday and civil date.
// -----------------------------------------------------------------------------
//
//   channel   dir   payload
//   s_*       in    timestamp and daylight-saving flag
//   m_*       out   second, minute, hour, weekday, day, month, year, flag
//
// One transaction per cycle sustained while m_tready is high; ten register
// stages, each at most one multiplier deep (reciprocal multiplies).
// rst_n clears only the stage valid bits; data registers are not reset.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// are squeezed out and s_tready stays high while the output register is free.
// A stalled m_* side holds its transaction; nothing is dropped or repeated.
// -----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_civil_date
    import escd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] seconds_since_1970, [33:32] dst_flag
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [5:0] second, [11:6] minute, [16:12] hour,
                                        // [19:17] weekday, [24:20] day_of_month,
                                        // [28:25] month_index, [36:29] years_since_1900,
                                        // [38:37] dst_out
);

    localparam int LAST = NUM_STAGES - 1;

    escd_stage_en_t stage_en;
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [1:0]  dst_reg [NUM_STAGES];
    escd_split_t split;
    escd_time_t  time_out;
    escd_date_t  date;

    // stage enables: ripple back from the output register
    always_comb
    begin
        stage_en[LAST] = !valid_reg[LAST] || m_tready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i + 1];
        end
    end

    always_comb
    begin
        valid_next[0] = stage_en[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = stage_en[i] ? valid_reg[i - 1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // daylight-saving flag rides alongside the arithmetic
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            dst_reg[0] <= s_tdata[33:32];
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (stage_en[i])
            begin
                dst_reg[i] <= dst_reg[i - 1];
            end
        end
    end

    escd_day_split u_day_split (
        .clk                (clk),
        .seconds_since_1970 (s_tdata[31:0]),
        .stage_en           (stage_en),
        .split              (split)
    );

    escd_time_of_day u_time_of_day (
        .clk      (clk),
        .tod      (split.tod),
        .stage_en (stage_en),
        .time_out (time_out)
    );

    escd_civil_date u_civil_date (
        .clk      (clk),
        .split    (split),
        .stage_en (stage_en),
        .date     (date)
    );

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = {1'b0, dst_reg[LAST], date.years_since_1900, date.month_index,
                       date.day_of_month, date.weekday, time_out.hour,
                       time_out.minute, time_out.second};

`include "epoch_seconds_to_civil_date_assert.svh"

    `ESCD_ASSERT_NOW(a_ready_when_out_free, !m_tvalid, s_tready, "input stalled with output free")
    `ESCD_ASSERT_NOW(a_time_range, m_tvalid,
        (m_tdata[5:0] < 6'd60) && (m_tdata[11:6] < 6'd60) && (m_tdata[16:12] < 5'd24),
        "time of day out of range")
    `ESCD_ASSERT_NOW(a_date_range, m_tvalid,
        (m_tdata[19:17] < 3'd7) && (m_tdata[28:25] < 4'd12) && (m_tdata[24:20] != 5'd0)
        && ((m_tdata[28:25] != 4'd1) || (m_tdata[24:20] <= 5'd29)),
        "calendar date out of range")
    `ESCD_ASSERT_NEXT(a_drain, m_tvalid && m_tready && !valid_reg[LAST - 1], !m_tvalid,
        "result delivered twice")

endmodule

`default_nettype wire
